// File: sv/mab_pkg.sv
package mab_pkg;

  localparam int CANVAS_PAGES     = 8;
  localparam int MAX_CANVAS_WIDTH = 128;
  localparam int IMAGE_BYTES      = 1024;
  localparam int CANVAS_BYTES     = CANVAS_PAGES * MAX_CANVAS_WIDTH;

  localparam int CA_W = $clog2(CANVAS_BYTES);
  localparam int IA_W = $clog2(IMAGE_BYTES);
  localparam int J_W  = $clog2(CANVAS_PAGES * 256) + 1;
  localparam int PG_W = 6;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_WRITE = 2'd3
  } req_type_e;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_PLACE = 2'd1;
  localparam logic [1:0] STAT_SIZE  = 2'd2;

  localparam logic [1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_CANVAS_HEIGHT = 2'd1;

  typedef struct packed {
    logic [1:0]      status;
    logic [15:0]     idx;
    logic [7:0]      iw;
    logic [PG_W-1:0] pg_start;
    logic [PG_W-1:0] pg_end;
    logic [2:0]      shift;
    logic [7:0]      mask;
    logic [7:0]      bm;
    logic            im_nz;
    logic [J_W-1:0]  base;
  } geom_t;

endpackage

// File: sv/mab_if.sv
interface mab_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [9:0]  image_index;
  logic [9:0]  canvas_index;
  logic [7:0]  pixel_byte;
  logic [7:0]  alpha_byte;
  logic        use_alpha;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [7:0]  img_width;
  logic [7:0]  img_height;

  modport source(output valid, req_type, image_index, canvas_index, pixel_byte, alpha_byte,
                 use_alpha, pos_x, pos_y, img_width, img_height, input ready);
  modport sink(input valid, req_type, image_index, canvas_index, pixel_byte, alpha_byte,
               use_alpha, pos_x, pos_y, img_width, img_height, output ready);
endinterface

interface mab_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] read_data;

  modport source(output valid, status, read_data, input ready);
  modport sink(input valid, status, read_data, output ready);
endinterface

interface mab_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/mab_ram.sv
module mab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// File: sv/mab_geom.sv
module mab_geom
  import mab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] px_i,
  input  logic [15:0] py_i,
  input  logic [7:0]  w_i,
  input  logic [7:0]  h_i,
  input  logic [7:0]  cw_i,
  input  logic [6:0]  ch_i,
  output logic        done_o,
  output geom_t       geom_o
);

  logic [3:0] v_q;

  // stage 0: operands
  logic [15:0] px_q, py_q;
  logic [7:0]  w_q, h_q;

  // stage 1: size check, clip origin
  logic [8:0]  hsum;
  logic [5:0]  pages;
  logic [13:0] prod;
  logic [16:0] mpy;
  logic [2:0]  off;
  logic [14:0] ay1;
  logic [16:0] dy1;
  logic [15:0] dx1;
  logic        big1_q, neg1_q;
  logic [14:0] ax1_q, ay1_q;
  logic [16:0] dy1_q;
  logic [15:0] dx1_q;

  // stage 2: start index, clipped size
  logic [21:0] prodi;
  logic        big2_q, oob2_q;
  logic [7:0]  ax2_q;
  logic [6:0]  ay2_q;
  logic [7:0]  iw2_q, ih2_q;
  logic [15:0] idx2_q;

  // stage 3
  logic [8:0]  xs, hs, ey, es;
  logic [7:0]  iw3, ih3;
  logic [PG_W-1:0] pst, pen;
  logic        pagebad;
  logic [2:0]  bsr;
  logic [7:0]  mask3, bm3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], start_i};
    end
  end

  always_comb begin
    hsum  = {1'b0, h_q} + 9'd7;
    pages = hsum[8:3];
    prod  = 14'(w_q) * 14'(pages);
    mpy   = 17'd0 - {py_q[15], py_q};
    off   = py_q[15] ? mpy[2:0] : py_q[2:0];
    if (py_q[15]) begin
      ay1 = (off != 3'd0 && mpy < {9'b0, h_q}) ? 15'(4'd8 - {1'b0, off}) : 15'd0;
    end else begin
      ay1 = py_q[14:0];
    end
    dy1 = {2'b0, ay1} - {py_q[15], py_q};
    dx1 = px_q[15] ? 16'(17'd0 - {px_q[15], px_q}) : 16'd0;
  end

  assign prodi = 22'(dy1_q[16:3]) * 22'(w_q);

  always_comb begin
    xs      = {1'b0, ax2_q} + {1'b0, iw2_q};
    iw3     = (xs > {1'b0, cw_i}) ? (cw_i - ax2_q) : iw2_q;
    hs      = {2'b0, ay2_q} + {1'b0, ih2_q};
    ih3     = (hs > {2'b0, ch_i}) ? 8'({1'b0, ch_i} - {1'b0, ay2_q}) : ih2_q;
    ey      = {2'b0, ay2_q} + {1'b0, ih3};
    es      = ey + 9'd7;
    pst     = PG_W'(ay2_q[6:3]);
    pen     = es[8:3];
    pagebad = (int'(pst) > CANVAS_PAGES - 1) || (int'(pen) > CANVAS_PAGES);
    bsr     = ey[2:0];
    mask3   = 8'hFF << ay2_q[2:0];
    bm3     = 8'hFF >> ((bsr != 3'd0) ? (4'd8 - {1'b0, bsr}) : 4'd0);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      px_q <= px_i;
      py_q <= py_i;
      w_q  <= w_i;
      h_q  <= h_i;
    end
    if (v_q[0]) begin
      big1_q <= int'(prod) > IMAGE_BYTES;
      neg1_q <= px_q[15] | py_q[15];
      ax1_q  <= px_q[15] ? 15'd0 : px_q[14:0];
      ay1_q  <= ay1;
      dy1_q  <= dy1;
      dx1_q  <= dx1;
    end
    if (v_q[1]) begin
      big2_q <= big1_q;
      oob2_q <= (ax1_q >= {7'b0, cw_i}) || (ay1_q >= {8'b0, ch_i});
      ax2_q  <= ax1_q[7:0];
      ay2_q  <= ay1_q[6:0];
      iw2_q  <= ({1'b0, dx1_q} >= {9'b0, w_q}) ? 8'd0 : 8'({9'b0, w_q} - {1'b0, dx1_q});
      ih2_q  <= (dy1_q >= {9'b0, h_q}) ? 8'd0 : 8'({9'b0, h_q} - dy1_q);
      idx2_q <= neg1_q ? (prodi[15:0] + dx1_q) : 16'd0;
    end
    if (v_q[2]) begin
      geom_o.status   <= big2_q ? STAT_SIZE :
                         ((oob2_q || pagebad) ? STAT_PLACE : STAT_OK);
      geom_o.idx      <= idx2_q;
      geom_o.iw       <= iw3;
      geom_o.pg_start <= pst;
      geom_o.pg_end   <= pen;
      geom_o.shift    <= ay2_q[2:0];
      geom_o.mask     <= mask3;
      geom_o.bm       <= bm3;
      geom_o.im_nz    <= (mask3 & bm3) != 8'd0;
      geom_o.base     <= J_W'(pst) * J_W'(cw_i) + J_W'(ax2_q);
    end
  end

  assign done_o = v_q[3];

endmodule

// File: sv/page_mono_alpha_blitter.sv
// Monochrome page blitter. Host requests load image bytes (data plus alpha), read or
// write canvas bytes, or draw the image at a signed position. Every request gives one
// response with a status and, for a read, the canvas byte. A draw first clips in the
// geometry unit, then for each touched canvas byte fetches the image byte above, the image
// byte under and does the canvas read-modify-write, all through one image RAM port and
// one canvas RAM port. No request is taken until the response of the previous one has
// been taken.
module page_mono_alpha_blitter
  import mab_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  mab_req_if.sink   req_i,
  mab_rsp_if.source rsp_o,
  mab_cfg_if.sink   cfg_i
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_GEOM = 7'b0000010,
    ST_PREV = 7'b0000100,
    ST_CUR  = 7'b0001000,
    ST_MRG  = 7'b0010000,
    ST_RDW  = 7'b0100000,
    ST_RESP = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] cw_q;
  logic [6:0] ch_q;

  logic [1:0]  status_q, status_d;
  logic [7:0]  rd_q, rd_d;
  logic        rd_ok_q, rd_ok_d;
  logic [7:0]  w_q;
  logic        ua_q;
  logic [15:0] idx_q, idx_d;
  logic [J_W-1:0] j_q, j_d, base_q, base_d;
  logic [PG_W-1:0] pg_q, pg_d;
  logic [7:0]  col_q, col_d;
  logic        prev_ok_q, prev_ok_d, cur_ok_q, cur_ok_d;
  logic [7:0]  pr_q, pr_d, pa_q, pa_d;

  logic        geom_start, geom_done;
  geom_t       g;

  logic            img_we, img_re, cv_we, cv_re;
  logic [IA_W-1:0] img_addr;
  logic [CA_W-1:0] cv_addr;
  logic [15:0]     img_wdata, img_rdata;
  logic [7:0]      cv_wdata, cv_rdata;

  logic [15:0] iidx_ext, cidx_ext;
  logic        load_ok, cidx_ok;
  logic [16:0] prev_ix;
  logic        prev_in, cur_in, j_in;
  logic [7:0]  cr, ca, c, top, img, bot;
  logic [3:0]  inv;
  logic        first_top, last_pg, last_col;

  mab_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (geom_start),
    .px_i    (req_i.pos_x),
    .py_i    (req_i.pos_y),
    .w_i     (req_i.img_width),
    .h_i     (req_i.img_height),
    .cw_i    (cw_q),
    .ch_i    (ch_q),
    .done_o  (geom_done),
    .geom_o  (g)
  );

  mab_ram #(.WIDTH(16), .DEPTH(IMAGE_BYTES)) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .re_i    (img_re),
    .addr_i  (img_addr),
    .wdata_i (img_wdata),
    .rdata_o (img_rdata)
  );

  mab_ram #(.WIDTH(8), .DEPTH(CANVAS_BYTES)) u_cv_ram (
    .clk_i   (clk_i),
    .we_i    (cv_we),
    .re_i    (cv_re),
    .addr_i  (cv_addr),
    .wdata_i (cv_wdata),
    .rdata_o (cv_rdata)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= 8'd128;
      ch_q <= 7'd64;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CANVAS_WIDTH:  cw_q <= cfg_i.data;
        CFG_CANVAS_HEIGHT: ch_q <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = (state_q == ST_RESP);
  assign rsp_o.status    = status_q;
  assign rsp_o.read_data = rd_q;

  assign iidx_ext = {6'b0, req_i.image_index};
  assign cidx_ext = {6'b0, req_i.canvas_index};
  assign load_ok  = int'(iidx_ext) < IMAGE_BYTES;
  assign cidx_ok  = int'(cidx_ext) < CANVAS_BYTES;

  assign prev_ix  = {1'b0, idx_q} - {9'b0, w_q};
  assign prev_in  = !prev_ix[16] && (int'(prev_ix) < IMAGE_BYTES);
  assign cur_in   = int'(idx_q) < IMAGE_BYTES;
  assign j_in     = int'(j_q) < CANVAS_BYTES;

  // byte merge
  always_comb begin
    c         = cv_rdata;
    cr        = cur_ok_q ? img_rdata[7:0] : 8'd0;
    ca        = ua_q ? (cur_ok_q ? img_rdata[15:8] : 8'd0) : 8'hFF;
    inv       = 4'd8 - {1'b0, g.shift};
    first_top = (pg_q == g.pg_start) && (idx_q < {8'b0, w_q});
    last_pg   = (pg_q == g.pg_end - PG_W'(1));
    last_col  = (col_q == g.iw - 8'd1);
    if (first_top) begin
      top = c & ~g.mask;
    end else begin
      top = (c & ~g.mask & ~((pa_q >> inv) & ~g.mask)) | ((pr_q & pa_q) >> inv);
    end
    img = c & g.mask & ~((ca << g.shift) & g.mask);
    if (!last_pg || g.im_nz) begin
      img = img | ((cr & ca) << g.shift);
    end
    bot = last_pg ? (c & ~g.bm) : 8'd0;
  end

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    rd_d       = rd_q;
    rd_ok_d    = rd_ok_q;
    idx_d      = idx_q;
    j_d        = j_q;
    base_d     = base_q;
    pg_d       = pg_q;
    col_d      = col_q;
    prev_ok_d  = prev_ok_q;
    cur_ok_d   = cur_ok_q;
    pr_d       = pr_q;
    pa_d       = pa_q;
    geom_start = 1'b0;
    img_we     = 1'b0;
    img_re     = 1'b0;
    img_addr   = req_i.image_index[IA_W-1:0];
    img_wdata  = {req_i.alpha_byte, req_i.pixel_byte};
    cv_we      = 1'b0;
    cv_re      = 1'b0;
    cv_addr    = CA_W'(cidx_ext);
    cv_wdata   = req_i.pixel_byte;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          status_d = STAT_OK;
          rd_d     = 8'd0;
          case (req_type_e'(req_i.req_type))
            REQ_LOAD: begin
              img_we  = load_ok;
              state_d = ST_RESP;
            end
            REQ_DRAW: begin
              geom_start = 1'b1;
              state_d    = ST_GEOM;
            end
            REQ_READ: begin
              cv_re   = cidx_ok;
              rd_ok_d = cidx_ok;
              state_d = ST_RDW;
            end
            default: begin
              cv_we   = cidx_ok;
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_GEOM: begin
        if (geom_done) begin
          status_d = g.status;
          idx_d    = g.idx;
          pg_d     = g.pg_start;
          col_d    = 8'd0;
          j_d      = g.base;
          base_d   = g.base;
          if (g.status != STAT_OK || g.iw == 8'd0 || g.pg_start >= g.pg_end) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_PREV;
          end
        end
      end
      ST_PREV: begin
        img_re    = 1'b1;
        img_addr  = prev_ix[IA_W-1:0];
        prev_ok_d = prev_in;
        cv_re     = 1'b1;
        cv_addr   = j_q[CA_W-1:0];
        state_d   = ST_CUR;
      end
      ST_CUR: begin
        pr_d     = prev_ok_q ? img_rdata[7:0] : 8'd0;
        pa_d     = ua_q ? (prev_ok_q ? img_rdata[15:8] : 8'd0) : 8'hFF;
        img_re   = 1'b1;
        img_addr = idx_q[IA_W-1:0];
        cur_ok_d = cur_in;
        state_d  = ST_MRG;
      end
      ST_MRG: begin
        cv_we    = j_in;
        cv_addr  = j_q[CA_W-1:0];
        cv_wdata = top | img | bot;
        idx_d    = idx_q + 16'd1;
        col_d    = col_q + 8'd1;
        j_d      = j_q + J_W'(1);
        state_d  = ST_PREV;
        if (last_col) begin
          col_d  = 8'd0;
          idx_d  = idx_q + 16'd1 + {8'b0, w_q} - {8'b0, g.iw};
          base_d = base_q + J_W'(cw_q);
          j_d    = base_q + J_W'(cw_q);
          pg_d   = pg_q + PG_W'(1);
          if (last_pg) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_RDW: begin
        rd_d    = rd_ok_q ? cv_rdata : 8'd0;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    rd_q      <= rd_d;
    rd_ok_q   <= rd_ok_d;
    idx_q     <= idx_d;
    j_q       <= j_d;
    base_q    <= base_d;
    pg_q      <= pg_d;
    col_q     <= col_d;
    prev_ok_q <= prev_ok_d;
    cur_ok_q  <= cur_ok_d;
    pr_q      <= pr_d;
    pa_q      <= pa_d;
    if (geom_start) begin
      w_q  <= req_i.img_width;
      ua_q <= req_i.use_alpha;
    end
  end

  a_req_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while busy");

  a_geom_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom_done |-> state_q == ST_GEOM)
    else $error("geometry result outside draw setup");

  a_walk_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MRG && cv_we) |-> int'(j_q) < CANVAS_BYTES)
    else $error("canvas write out of range");

  a_merge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MRG |-> $past(state_q) == ST_CUR)
    else $error("merge without image fetch");

endmodule

// File: tb/tb_page_mono_alpha_blitter.sv
module tb_page_mono_alpha_blitter
  import mab_pkg::*;
;

  typedef struct {
    req_type_e   kind;
    logic [9:0]  image_index;
    logic [9:0]  canvas_index;
    logic [7:0]  pixel_byte;
    logic [7:0]  alpha_byte;
    logic        use_alpha;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  img_width;
    logic [7:0]  img_height;
  } request_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] read_data;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mab_req_if req ();
  mab_rsp_if rsp ();
  mab_cfg_if cfg ();

  page_mono_alpha_blitter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  always #4 clk_i = ~clk_i;

  request_t  pending_q[$];
  response_t expected_q[$];

  logic [7:0]  canvas_mem[CANVAS_BYTES];
  logic [15:0] image_mem[IMAGE_BYTES];
  int canvas_w = 128;
  int canvas_h = 64;

  int  errors = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  stall = 0;
  int  hold_cnt = 0;
  bit  hold_req = 1'b0;
  bit  req_taken = 1'b0;
  bit  rsp_taken = 1'b0;
  bit  no_gaps = 1'b0;

  function automatic logic [15:0] image_fetch(int x, bit ua);
    logic [15:0] v;
    v = (x >= 0 && x < IMAGE_BYTES) ? image_mem[x] : 16'h0;
    return {ua ? v[15:8] : 8'hff, v[7:0]};
  endfunction

  function automatic logic [1:0] blit(int px, int py, int w, int h, bit ua);
    int cw, ch, off, ax, ay, iw, ih, st, en, i, k, base, j, idx, shift, bs;
    logic [7:0] mask, bm, im, c, r, a, top, img, bot;
    logic [15:0] f;
    cw = canvas_w;
    ch = canvas_h;
    if (w * ((h + 7) / 8) > IMAGE_BYTES) return STAT_SIZE;
    off = py % 8;
    if (off < 0) off = -off;
    ax = px < 0 ? 0 : px;
    ay = py < 0 ? ((off != 0 && -py < h) ? 8 - off : 0) : py;
    if (px >= 0 && py >= 0) idx = 0;
    else idx = (((ay - py) / 8) * w + (px < 0 ? -px : 0)) & 16'hffff;
    iw = w - (ax - px);
    if (iw < 0) iw = 0;
    ih = h - (ay - py);
    if (ih < 0) ih = 0;
    if (ax > cw - 1 || ay > ch - 1) return STAT_PLACE;
    if (ax + iw > cw) iw = cw - ax;
    if (ay + ih > ch) ih = ch - ay;
    st = ay / 8;
    en = (ay + ih + 7) / 8;
    if (st > CANVAS_PAGES - 1 || en > CANVAS_PAGES) return STAT_PLACE;
    shift = ay % 8;
    bs = ((ay + ih) % 8) != 0 ? 8 - ((ay + ih) % 8) : 0;
    mask = 8'hff << shift;
    bm = 8'hff >> bs;
    im = mask & bm;
    for (i = st; i < en; i++) begin
      base = i * cw + ax;
      for (k = 0; k < iw; k++) begin
        j = base + k;
        c = (j >= 0 && j < CANVAS_BYTES) ? canvas_mem[j] : 8'h0;
        if (i == st && idx < w) begin
          top = c & ~mask;
        end else begin
          f = image_fetch(idx - w, ua);
          r = f[7:0];
          a = f[15:8];
          top = c & ~mask & ~((a >> (8 - shift)) & ~mask);
          top = top | ((r & a) >> (8 - shift));
        end
        f = image_fetch(idx, ua);
        r = f[7:0];
        a = f[15:8];
        img = c & mask & ~((a << shift) & mask);
        if (i != en - 1 || im != 0) img = img | ((r & a) << shift);
        bot = (i == en - 1) ? (c & ~bm) : 8'h0;
        if (j >= 0 && j < CANVAS_BYTES) canvas_mem[j] = top | img | bot;
        idx = (idx + 1) & 16'hffff;
      end
      idx = (idx + (w - iw)) & 16'hffff;
    end
    return STAT_OK;
  endfunction

  function automatic response_t predict_response(request_t q);
    response_t p;
    p.status = STAT_OK;
    p.read_data = 8'h0;
    case (q.kind)
      REQ_LOAD: image_mem[q.image_index] = {q.alpha_byte, q.pixel_byte};
      REQ_DRAW: p.status = blit($signed(q.pos_x), $signed(q.pos_y),
                                q.img_width, q.img_height, q.use_alpha);
      REQ_READ: p.read_data = canvas_mem[q.canvas_index];
      default: canvas_mem[q.canvas_index] = q.pixel_byte;
    endcase
    return p;
  endfunction

  function automatic request_t rand_request(req_type_e kind);
    request_t q;
    q.kind = kind;
    q.image_index = 10'($urandom);
    q.canvas_index = 10'($urandom);
    q.pixel_byte = 8'($urandom);
    q.alpha_byte = 8'($urandom);
    q.use_alpha = 1'($urandom);
    q.pos_x = 16'($urandom);
    q.pos_y = 16'($urandom);
    q.img_width = 8'($urandom);
    q.img_height = 8'($urandom);
    return q;
  endfunction

  function automatic void push_draw(int x, int y, int w, int h, bit ua);
    request_t q;
    q = rand_request(REQ_DRAW);
    q.pos_x = 16'(x);
    q.pos_y = 16'(y);
    q.img_width = 8'(w);
    q.img_height = 8'(h);
    q.use_alpha = ua;
    pending_q.push_back(q);
  endfunction

  function automatic void push_random(int n);
    request_t q;
    int sel;
    for (int t = 0; t < n; t++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) q = rand_request(REQ_LOAD);
      else if (sel < 40) q = rand_request(REQ_WRITE);
      else if (sel < 62) q = rand_request(REQ_READ);
      else begin
        q = rand_request(REQ_DRAW);
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
          q.img_width = 8'($urandom_range(0, 20));
          q.img_height = 8'($urandom_range(0, 24));
          q.pos_x = 16'($urandom_range(0, canvas_w + 8) - 10);
          q.pos_y = 16'($urandom_range(0, canvas_h + 12) - 14);
        end else if (sel < 95) begin
          q.img_width = 8'($urandom_range(0, 128));
          q.img_height = 8'($urandom_range(0, 64));
          q.pos_x = 16'($urandom_range(0, canvas_w + 40) - 40);
          q.pos_y = 16'($urandom_range(0, canvas_h + 30) - 30);
        end
      end
      pending_q.push_back(q);
    end
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || req.valid || expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] index, logic [7:0] data);
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.index = index;
    cfg.data = data;
    do @(posedge clk_i); while (!cfg.ready);
    if (index == CFG_CANVAS_WIDTH) canvas_w = data;
    else canvas_h = data[6:0];
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (req_taken) begin
      req.valid = 1'b0;
      req_taken = 1'b0;
      send_gap = no_gaps ? 0 : $urandom_range(0, 7);
    end
    if (!req.valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_q.size() != 0) begin
        request_t q;
        q = pending_q.pop_front();
        req.req_type = q.kind;
        req.image_index = q.image_index;
        req.canvas_index = q.canvas_index;
        req.pixel_byte = q.pixel_byte;
        req.alpha_byte = q.alpha_byte;
        req.use_alpha = q.use_alpha;
        req.pos_x = q.pos_x;
        req.pos_y = q.pos_y;
        req.img_width = q.img_width;
        req.img_height = q.img_height;
        req.valid = 1'b1;
      end
    end
  end

  // response ready with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (rsp_taken) begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      rsp_taken = 1'b0;
    end
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      rsp.ready = 1'b0;
      hold_cnt--;
    end else if (stall > 0) begin
      rsp.ready = 1'b0;
      stall--;
    end else begin
      rsp.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 10000000) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_ni && req.valid && req.ready) begin
      request_t q;
      q.kind = req_type_e'(req.req_type);
      q.image_index = req.image_index;
      q.canvas_index = req.canvas_index;
      q.pixel_byte = req.pixel_byte;
      q.alpha_byte = req.alpha_byte;
      q.use_alpha = req.use_alpha;
      q.pos_x = req.pos_x;
      q.pos_y = req.pos_y;
      q.img_width = req.img_width;
      q.img_height = req.img_height;
      expected_q.push_back(predict_response(q));
      req_taken = 1'b1;
    end
    if (rst_ni && rsp.valid && rsp.ready) begin
      rsp_taken = 1'b1;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected response status %0d data %02h", $time,
                 rsp.status, rsp.read_data);
        errors++;
      end else begin
        response_t e;
        e = expected_q.pop_front();
        if (rsp.status !== e.status) begin
          $display("%0t status expected %0d actual %0d", $time, e.status, rsp.status);
          errors++;
        end
        if (rsp.read_data !== e.read_data) begin
          $display("%0t read_data expected %02h actual %02h", $time, e.read_data,
                   rsp.read_data);
          errors++;
        end
      end
    end
  end

  initial begin
    request_t q;
    req.valid = 1'b0;
    req.req_type = REQ_LOAD;
    req.image_index = '0;
    req.canvas_index = '0;
    req.pixel_byte = '0;
    req.alpha_byte = '0;
    req.use_alpha = 1'b0;
    req.pos_x = '0;
    req.pos_y = '0;
    req.img_width = '0;
    req.img_height = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_CANVAS_WIDTH;
    cfg.data = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill both stores so nothing undefined is ever read
    no_gaps = 1'b1;
    for (int n = 0; n < IMAGE_BYTES; n++) begin
      q = rand_request(REQ_LOAD);
      q.image_index = 10'(n);
      pending_q.push_back(q);
    end
    for (int n = 0; n < CANVAS_BYTES; n++) begin
      q = rand_request(REQ_WRITE);
      q.canvas_index = 10'(n);
      pending_q.push_back(q);
    end
    wait_idle();
    no_gaps = 1'b0;

    // directed corners
    push_draw(0, 0, 8, 8, 1'b1);
    push_draw(3, 5, 10, 13, 1'b1);
    push_draw(-4, -3, 12, 20, 1'b0);
    push_draw(-5, -11, 9, 30, 1'b1);
    push_draw(2, 3, 6, 0, 1'b1);
    push_draw(4, 4, 0, 8, 1'b0);
    push_draw(0, 0, 255, 255, 1'b1);
    push_draw(-32768, -32768, 4, 4, 1'b1);
    push_draw(32767, 32767, 4, 4, 1'b0);
    push_draw(127, 63, 8, 8, 1'b1);
    push_draw(128, 0, 8, 8, 1'b1);
    push_draw(0, 64, 8, 8, 1'b1);
    push_draw(120, 56, 128, 64, 1'b1);
    push_draw(0, 0, 128, 64, 1'b0);
    push_draw(-1, -1, 255, 16, 1'b1);
    q = rand_request(REQ_READ);
    q.canvas_index = 0;
    pending_q.push_back(q);
    q.canvas_index = 1023;
    pending_q.push_back(q);
    q = rand_request(REQ_LOAD);
    q.image_index = 1023;
    q.pixel_byte = 8'hff;
    q.alpha_byte = 8'h00;
    pending_q.push_back(q);
    q = rand_request(REQ_WRITE);
    q.canvas_index = 1023;
    q.pixel_byte = 8'h00;
    pending_q.push_back(q);
    push_random(120);
    wait_idle();
    pending_q.delete();
    push_random(40);
    hold_req = 1'b1;
    wait_idle();

    cfg_write(CFG_CANVAS_WIDTH, 8'd1);
    cfg_write(CFG_CANVAS_HEIGHT, 8'd8);
    push_draw(0, 0, 4, 8, 1'b1);
    push_draw(0, 3, 1, 9, 1'b1);
    push_random(100);
    wait_idle();

    cfg_write(CFG_CANVAS_WIDTH, 8'd37);
    cfg_write(CFG_CANVAS_HEIGHT, 8'd23);
    no_gaps = 1'b1;
    push_random(60);
    wait_idle();
    no_gaps = 1'b0;
    push_random(60);
    wait_idle();

    cfg_write(CFG_CANVAS_WIDTH, 8'd128);
    cfg_write(CFG_CANVAS_HEIGHT, 8'd64);
    push_random(180);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: page_mono_alpha_blitter.f
sv/mab_pkg.sv
sv/mab_if.sv
sv/mab_ram.sv
sv/mab_geom.sv
sv/page_mono_alpha_blitter.sv
tb/tb_page_mono_alpha_blitter.sv
